// ===== rtl/lss_pkg.sv =====
// Package with the shared types, codes and constants of the line sensor steering sequencer.
`default_nettype none

package lss_pkg;

	localparam int SENSOR_COUNT = 16;
	localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);

	typedef logic [SENSOR_COUNT-1:0] sensor_t;

	typedef logic [2:0] action_t;
	localparam action_t ACT_STOP       = 3'd0;
	localparam action_t ACT_PID        = 3'd1;
	localparam action_t ACT_HOLD       = 3'd2;
	localparam action_t ACT_FORWARD    = 3'd3;
	localparam action_t ACT_SPIN_LEFT  = 3'd4;
	localparam action_t ACT_SPIN_RIGHT = 3'd5;

	typedef logic [2:0] cls_t;
	localparam cls_t CLS_STOP  = 3'd0;
	localparam cls_t CLS_PID   = 3'd1;
	localparam cls_t CLS_HOLD  = 3'd2;
	localparam cls_t CLS_LEFT  = 3'd3;
	localparam cls_t CLS_RIGHT = 3'd4;

	typedef logic [1:0] reg_index_t;
	localparam reg_index_t REG_SPIN_SPEED    = 2'd0;
	localparam reg_index_t REG_FORWARD_SPEED = 2'd1;
	localparam reg_index_t REG_FORWARD_TICKS = 2'd2;

	localparam int CFG_DATA_W = 16;

	localparam logic [7:0]  SPIN_SPEED_RESET    = 8'd100;
	localparam logic [7:0]  FORWARD_SPEED_RESET = 8'd100;
	localparam logic [15:0] FORWARD_TICKS_RESET = 16'd200;

	localparam sensor_t CENTER_PATTERN = 16'h03C0;

	typedef struct packed {
		logic [7:0]  spin_speed;
		logic [7:0]  forward_speed;
		logic [15:0] forward_ticks;
	} cfg_t;

	// Outcome of the front classifier for one sample.
	typedef struct packed {
		cls_t cls;
		logic center;
		logic full_on;
	} class_t;

	typedef struct packed {
		action_t    action;
		logic       left_dir;
		logic [7:0] left_speed;
		logic       right_dir;
		logic [7:0] right_speed;
		logic       clear_error;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/lss_sample_if.sv =====
// Channel interface that carries one sensor sample word.
`default_nettype none

interface lss_sample_if;
	import lss_pkg::*;

	logic    valid;
	logic    ready;
	sensor_t sensor_bits;

	modport source(output valid, output sensor_bits, input ready);
	modport sink(input valid, input sensor_bits, output ready);
endinterface

`default_nettype wire

// ===== rtl/lss_result_if.sv =====
// Channel interface that carries one motor command word.
`default_nettype none

interface lss_result_if;
	import lss_pkg::*;

	logic       valid;
	logic       ready;
	action_t    action;
	logic       left_dir;
	logic [7:0] left_speed;
	logic       right_dir;
	logic [7:0] right_speed;
	logic       clear_error;

	modport source(output valid, output action, output left_dir, output left_speed,
		output right_dir, output right_speed, output clear_error, input ready);
	modport sink(input valid, input action, input left_dir, input left_speed,
		input right_dir, input right_speed, input clear_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/line_sensor_steering_sequencer_unit.sv =====
// Top level of the line sensor steering sequencer with its configuration registers.
//
//   Channel   Dir  Handshake          Word
//   sample    in   valid/ready        sensor_bits[15:0]
//   result    out  valid/ready        action, left/right dir and speed, clear_error
//   cfg       in   cfg_wr_en only     cfg_index[1:0], cfg_data[15:0]
//
// A sample is classified as it is accepted and sits in a two-entry queue.
// The back sequencer takes one word per cycle while the result is not stalled and registers
// its command, so each accepted sample reaches the result through the queue and that register.
// A stalled result holds the back; the queue keeps the input ready for up to two more words.
// Reset puts the sequencer in follow mode and loads the default speeds and tick count.
`default_nettype none

module line_sensor_steering_sequencer_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	lss_sample_if.sink                        sample,
	lss_result_if.source                      result,
	input  wire                               cfg_wr_en,
	input  wire  lss_pkg::reg_index_t         cfg_index,
	input  wire  logic [lss_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lss_pkg::*;

	cfg_t    cfg_q;
	class_t  front_cls;
	class_t  q_data;
	logic    q_valid, q_ready;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spin_speed    <= SPIN_SPEED_RESET;
			cfg_q.forward_speed <= FORWARD_SPEED_RESET;
			cfg_q.forward_ticks <= FORWARD_TICKS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SPIN_SPEED:    cfg_q.spin_speed    <= cfg_data[7:0];
				REG_FORWARD_SPEED: cfg_q.forward_speed <= cfg_data[7:0];
				REG_FORWARD_TICKS: cfg_q.forward_ticks <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	lss_front u_front (
		.sensor_bits (sample.sensor_bits),
		.cls_out     (front_cls)
	);

	lss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (sample.valid),
		.push_ready (sample.ready),
		.push_data  (front_cls),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	lss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res)
	);

	assign result.action      = res.action;
	assign result.left_dir    = res.left_dir;
	assign result.left_speed  = res.left_speed;
	assign result.right_dir   = res.right_dir;
	assign result.right_speed = res.right_speed;
	assign result.clear_error = res.clear_error;

endmodule

`default_nettype wire

// ===== rtl/lss_front.sv =====
// Front classifier: popcount, divisibility tests, exact patterns and edge masks.
`default_nettype none

module lss_front (
	input  wire  lss_pkg::sensor_t sensor_bits,
	output lss_pkg::class_t        cls_out
);
	import lss_pkg::*;

	localparam sensor_t L4_A = 16'hC180;
	localparam sensor_t L4_B = 16'h8380;
	localparam sensor_t L4_C = 16'h81C0;
	localparam sensor_t R4_A = 16'h0183;
	localparam sensor_t R4_B = 16'h0381;
	localparam sensor_t R4_C = 16'h01C1;
	localparam sensor_t L5_A = 16'hC380;
	localparam sensor_t L5_B = 16'hC1C0;
	localparam sensor_t L5_C = 16'h83C0;
	localparam sensor_t R5_A = 16'h0383;
	localparam sensor_t R5_B = 16'h01C3;
	localparam sensor_t R5_C = 16'h03C1;

	logic [2:0]       nib_cnt [4];
	logic [CNT_W-1:0] ones;
	logic [4:0]       sum3;
	logic [3:0]       fold3;
	logic [5:0]       sum7;
	logic [3:0]       fold7;
	logic [5:0]       sum15;
	logic [4:0]       fold15;
	logic [6:0]       sum31;
	logic [5:0]       fold31;
	logic             div3, div7, div15, div31;
	sensor_t          v;
	cls_t             cls;

	assign v = sensor_bits;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			nib_cnt[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
		end
		ones = CNT_W'(nib_cnt[0]) + CNT_W'(nib_cnt[1]) + CNT_W'(nib_cnt[2])
			+ CNT_W'(nib_cnt[3]);
	end

	// Divisibility by 2^k-1 through sums of k-bit digits, folded once more.
	always_comb begin
		sum3 = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8])
			+ 5'(v[11:10]) + 5'(v[13:12]) + 5'(v[15:14]);
		fold3 = 4'(sum3[4:2]) + 4'(sum3[1:0]);
		div3 = (fold3 == 4'd0) || (fold3 == 4'd3) || (fold3 == 4'd6) || (fold3 == 4'd9);

		sum7 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
			+ 6'(v[15]);
		fold7 = 4'(sum7[5:3]) + 4'(sum7[2:0]);
		div7 = (fold7 == 4'd0) || (fold7 == 4'd7);

		sum15 = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
		fold15 = 5'(sum15[5:4]) + 5'(sum15[3:0]);
		div15 = (fold15 == 5'd0) || (fold15 == 5'd15);

		sum31 = 7'(v[4:0]) + 7'(v[9:5]) + 7'(v[14:10]) + 7'(v[15]);
		fold31 = 6'(sum31[6:5]) + 6'(sum31[4:0]);
		div31 = (fold31 == 6'd0) || (fold31 == 6'd31);
	end

	function automatic cls_t edge_rule(sensor_t s, sensor_t low_mask, sensor_t high_mask);
		cls_t c;
		if ((s & low_mask) == '0) c = CLS_LEFT;
		else if ((s & high_mask) == '0) c = CLS_RIGHT;
		else c = CLS_HOLD;
		return c;
	endfunction

	always_comb begin
		case (ones)
			5'd0: cls = CLS_STOP;
			5'd1: cls = CLS_PID;
			5'd2: cls = div3 ? CLS_PID : CLS_HOLD;
			5'd3: cls = div7 ? CLS_PID : CLS_HOLD;
			5'd4: begin
				if (div15) cls = CLS_PID;
				else if (v == L4_A || v == L4_B || v == L4_C) cls = CLS_LEFT;
				else if (v == R4_A || v == R4_B || v == R4_C) cls = CLS_RIGHT;
				else cls = CLS_HOLD;
			end
			5'd5: begin
				if (div31) cls = CLS_PID;
				else if (v == L5_A || v == L5_B || v == L5_C) cls = CLS_LEFT;
				else if (v == R5_A || v == R5_B || v == R5_C) cls = CLS_RIGHT;
				else cls = CLS_HOLD;
			end
			5'd6, 5'd7:   cls = edge_rule(v, 16'h003F, 16'hFC00);
			5'd8, 5'd9:   cls = edge_rule(v, 16'h001F, 16'hF800);
			5'd10, 5'd11: cls = edge_rule(v, 16'h000F, 16'hF000);
			5'd12, 5'd13: cls = edge_rule(v, 16'h0007, 16'hE000);
			5'd14:        cls = edge_rule(v, 16'h0003, 16'hC000);
			default:      cls = CLS_LEFT;
		endcase
	end

	assign cls_out.cls     = cls;
	assign cls_out.center  = (v == CENTER_PATTERN);
	assign cls_out.full_on = (ones >= 5'd15);

endmodule

`default_nettype wire

// ===== rtl/lss_queue.sv =====
// Two-entry queue of classified words between the front and the back.
`default_nettype none

module lss_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push_valid,
	output logic                  push_ready,
	input  wire  lss_pkg::class_t push_data,
	output logic                  pop_valid,
	input  wire                   pop_ready,
	output lss_pkg::class_t       pop_data
);
	import lss_pkg::*;

	class_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lss_back.sv =====
// Back sequencer: follow, forward and spin modes, and the registered motor command.
`default_nettype none

module lss_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  lss_pkg::cfg_t   cfg,
	input  wire                   q_valid,
	output logic                  q_ready,
	input  wire  lss_pkg::class_t q_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output lss_pkg::result_t      out_data
);
	import lss_pkg::*;

	localparam logic [1:0] MODE_FOLLOW  = 2'd0;
	localparam logic [1:0] MODE_FORWARD = 2'd1;
	localparam logic [1:0] MODE_SPIN    = 2'd2;

	logic [1:0]  mode_q, nxt_mode;
	logic        side_q, nxt_side;
	logic [15:0] tick_q, nxt_tick;
	logic        clr_q, nxt_clr;
	logic        out_valid_q;
	result_t     res_q, res;
	logic        take, do_spin;

	assign q_ready   = !out_valid_q || out_ready;
	assign take      = q_valid && q_ready;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	always_comb begin
		nxt_mode = mode_q;
		nxt_side = side_q;
		nxt_tick = tick_q;
		nxt_clr  = clr_q;
		res      = '0;
		do_spin  = 1'b0;
		case (mode_q)
			MODE_FORWARD: begin
				if (tick_q >= cfg.forward_ticks) begin
					do_spin = 1'b1;
				end else begin
					res.action      = ACT_FORWARD;
					res.left_dir    = 1'b1;
					res.left_speed  = cfg.forward_speed;
					res.right_speed = cfg.forward_speed;
					nxt_tick        = tick_q + 16'd1;
				end
			end
			MODE_SPIN: do_spin = 1'b1;
			default: begin
				nxt_mode = MODE_FOLLOW;
				case (q_data.cls)
					CLS_STOP: res.action = ACT_STOP;
					CLS_PID:  res.action = ACT_PID;
					CLS_LEFT, CLS_RIGHT: begin
						nxt_side        = (q_data.cls == CLS_RIGHT);
						nxt_clr         = q_data.full_on;
						nxt_mode        = MODE_FORWARD;
						nxt_tick        = 16'd1;
						res.action      = ACT_FORWARD;
						res.left_dir    = 1'b1;
						res.left_speed  = cfg.forward_speed;
						res.right_speed = cfg.forward_speed;
					end
					default:  res.action = ACT_HOLD;
				endcase
			end
		endcase

		if (do_spin) begin
			nxt_mode = MODE_SPIN;
			if (q_data.center) begin
				res.action      = ACT_STOP;
				res.clear_error = clr_q;
				nxt_clr         = 1'b0;
				nxt_mode        = MODE_FOLLOW;
				nxt_tick        = 16'd0;
			end else begin
				res.action      = side_q ? ACT_SPIN_RIGHT : ACT_SPIN_LEFT;
				res.left_dir    = !side_q;
				res.right_dir   = !side_q;
				res.left_speed  = cfg.spin_speed;
				res.right_speed = cfg.spin_speed;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_FOLLOW;
			side_q      <= 1'b0;
			tick_q      <= 16'd0;
			clr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				mode_q <= nxt_mode;
				side_q <= nxt_side;
				tick_q <= nxt_tick;
				clr_q  <= nxt_clr;
			end
			if (q_ready) out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= res;
	end

endmodule

`default_nettype wire

// ===== rtl/lss_checker.sv =====
// Port-level checker for the sequencer and the bind that attaches it.
`default_nettype none

module lss_port_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire [2:0] action,
	input wire       left_dir,
	input wire [7:0] left_speed,
	input wire       right_dir,
	input wire [7:0] right_speed,
	input wire       clear_error
);
	import lss_pkg::*;

	a_action_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action <= ACT_SPIN_RIGHT))
		else $error("Action code out of range.");

	a_clear_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clear_error) |-> (action == ACT_STOP))
		else $error("Error clear requested on a word that is not a stop.");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (action == ACT_PID || action == ACT_HOLD || action == ACT_STOP))
		|-> (!left_dir && !right_dir && left_speed == 8'd0 && right_speed == 8'd0))
		else $error("Motor fields are not zero on a stop, run pid or hold word.");

	a_turn_dirs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (action == ACT_FORWARD || action == ACT_SPIN_LEFT
			|| action == ACT_SPIN_RIGHT))
		|-> (left_speed == right_speed
			&& left_dir == (action != ACT_SPIN_RIGHT)
			&& right_dir == (action == ACT_SPIN_LEFT)))
		else $error("Motor directions or speeds do not match the action.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(action)
			&& $stable(clear_error)))
		else $error("Stalled result word changed.");

endmodule

bind line_sensor_steering_sequencer_unit lss_port_checker u_lss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.action      (result.action),
	.left_dir    (result.left_dir),
	.left_speed  (result.left_speed),
	.right_dir   (result.right_dir),
	.right_speed (result.right_speed),
	.clear_error (result.clear_error)
);

`default_nettype wire

// ===== bench/lss_checker.sv =====
// Checker that predicts and compares the motor command words of the line sensor steering sequencer.
module lss_checker
	import lss_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  sample_valid,
	input  wire                  sample_ready,
	input  sensor_t              sample_bits,
	input  wire                  result_valid,
	input  wire                  result_ready,
	input  result_t              result_word,
	input  wire                  cfg_wr_en,
	input  reg_index_t           cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	output int                   pending,
	output int                   fail_count,
	output int                   words_checked,
	output int                   turns_done,
	output int                   clears_done
);

	typedef enum logic [1:0] {FOLLOWING, DRIVING, SPINNING} seq_mode_t;

	logic [7:0]  spin_duty;
	logic [7:0]  fwd_duty;
	logic [15:0] fwd_len;

	seq_mode_t   mode;
	logic        turn_right;
	logic [15:0] ticks;
	logic        clear_pending;

	result_t     command_q[$];
	int          fails = 0;
	int          checked = 0;
	int          turns = 0;
	int          clears = 0;

	function automatic int ones(sensor_t v);
		int n;
		n = 0;
		for (int i = 0; i < SENSOR_COUNT; i++) n += v[i];
		return n;
	endfunction

	function automatic cls_t edge_side(sensor_t v, sensor_t low_mask, sensor_t high_mask);
		if ((v & low_mask) == 0) return CLS_LEFT;
		if ((v & high_mask) == 0) return CLS_RIGHT;
		return CLS_HOLD;
	endfunction

	function automatic cls_t classify(sensor_t v);
		case (ones(v))
			0: return CLS_STOP;
			1: return CLS_PID;
			2: return (v % 3 == 0) ? CLS_PID : CLS_HOLD;
			3: return (v % 7 == 0) ? CLS_PID : CLS_HOLD;
			4: begin
				if (v % 15 == 0) return CLS_PID;
				if (v == 16'hC180 || v == 16'h8380 || v == 16'h81C0) return CLS_LEFT;
				if (v == 16'h0183 || v == 16'h0381 || v == 16'h01C1) return CLS_RIGHT;
				return CLS_HOLD;
			end
			5: begin
				if (v % 31 == 0) return CLS_PID;
				if (v == 16'hC380 || v == 16'hC1C0 || v == 16'h83C0) return CLS_LEFT;
				if (v == 16'h0383 || v == 16'h01C3 || v == 16'h03C1) return CLS_RIGHT;
				return CLS_HOLD;
			end
			6, 7:   return edge_side(v, 16'h003F, 16'hFC00);
			8, 9:   return edge_side(v, 16'h001F, 16'hF800);
			10, 11: return edge_side(v, 16'h000F, 16'hF000);
			12, 13: return edge_side(v, 16'h0007, 16'hE000);
			14:     return edge_side(v, 16'h0003, 16'hC000);
			default: return CLS_LEFT;
		endcase
	endfunction

	function automatic result_t command(action_t act, logic ld, logic [7:0] ls, logic rd,
		logic [7:0] rs, logic clr);
		result_t r;
		r.action      = act;
		r.left_dir    = ld;
		r.left_speed  = ls;
		r.right_dir   = rd;
		r.right_speed = rs;
		r.clear_error = clr;
		return r;
	endfunction

	task automatic spin_step(input sensor_t v, output result_t r);
		mode = SPINNING;
		if (v == CENTER_PATTERN) begin
			r = command(ACT_STOP, 1'b0, 8'd0, 1'b0, 8'd0, clear_pending);
			turns++;
			if (clear_pending) clears++;
			clear_pending = 1'b0;
			mode = FOLLOWING;
			ticks = 16'd0;
		end else if (turn_right) begin
			r = command(ACT_SPIN_RIGHT, 1'b0, spin_duty, 1'b0, spin_duty, 1'b0);
		end else begin
			r = command(ACT_SPIN_LEFT, 1'b1, spin_duty, 1'b1, spin_duty, 1'b0);
		end
	endtask

	task automatic predict(input sensor_t v, output result_t r);
		cls_t c;
		if (mode == DRIVING && ticks < fwd_len) begin
			r = command(ACT_FORWARD, 1'b1, fwd_duty, 1'b0, fwd_duty, 1'b0);
			ticks = ticks + 16'd1;
		end else if (mode == DRIVING || mode == SPINNING) begin
			spin_step(v, r);
		end else begin
			mode = FOLLOWING;
			c = classify(v);
			case (c)
				CLS_STOP: r = command(ACT_STOP, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0);
				CLS_PID:  r = command(ACT_PID, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0);
				CLS_HOLD: r = command(ACT_HOLD, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0);
				default: begin
					turn_right    = (c == CLS_RIGHT);
					clear_pending = (ones(v) >= 15);
					mode          = DRIVING;
					ticks         = 16'd1;
					r = command(ACT_FORWARD, 1'b1, fwd_duty, 1'b0, fwd_duty, 1'b0);
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			spin_duty     = SPIN_SPEED_RESET;
			fwd_duty      = FORWARD_SPEED_RESET;
			fwd_len       = FORWARD_TICKS_RESET;
			mode          = FOLLOWING;
			turn_right    = 1'b0;
			ticks         = 16'd0;
			clear_pending = 1'b0;
			command_q.delete();
			pending       <= 0;
			fail_count    <= fails;
			words_checked <= checked;
			turns_done    <= turns;
			clears_done   <= clears;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SPIN_SPEED:    spin_duty = cfg_data[7:0];
					REG_FORWARD_SPEED: fwd_duty  = cfg_data[7:0];
					REG_FORWARD_TICKS: fwd_len   = cfg_data[15:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (command_q.size() == 0) begin
					if (fails < 10)
						$display("unexpected command word: act=%0d ld=%0d ls=%0d rd=%0d rs=%0d clr=%0d",
							result_word.action, result_word.left_dir, result_word.left_speed,
							result_word.right_dir, result_word.right_speed, result_word.clear_error);
					fails++;
				end else begin
					want = command_q.pop_front();
					checked++;
					if (result_word.action !== want.action || result_word.left_dir !== want.left_dir
						|| result_word.left_speed !== want.left_speed
						|| result_word.right_dir !== want.right_dir
						|| result_word.right_speed !== want.right_speed
						|| result_word.clear_error !== want.clear_error) begin
						if (fails < 10) begin
							$display("command word %0d mismatch at %0t", checked, $realtime);
							$display("  expected act=%0d ld=%0d ls=%0d rd=%0d rs=%0d clr=%0d",
								want.action, want.left_dir, want.left_speed,
								want.right_dir, want.right_speed, want.clear_error);
							$display("  actual   act=%0d ld=%0d ls=%0d rd=%0d rs=%0d clr=%0d",
								result_word.action, result_word.left_dir, result_word.left_speed,
								result_word.right_dir, result_word.right_speed,
								result_word.clear_error);
						end
						fails++;
					end
				end
			end
			if (sample_valid && sample_ready) begin
				predict(sample_bits, want);
				command_q.push_back(want);
			end
			pending       <= command_q.size();
			fail_count    <= fails;
			words_checked <= checked;
			turns_done    <= turns;
			clears_done   <= clears;
		end
	end

endmodule

// ===== bench/tb.sv =====
// Top of the line sensor steering sequencer testbench: clock, reset, stimulus and verdict.
module tb;
	import lss_pkg::*;

	localparam reg_index_t REG_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	reg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit          steady;
	int          sent;
	int          settings;
	logic [15:0] cur_ticks;

	int pending;
	int fail_count;
	int words_checked;
	int turns_done;
	int clears_done;

	lss_sample_if sample_ch();
	lss_result_if result_ch();

	line_sensor_steering_sequencer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lss_checker command_check (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_ch.valid),
		.sample_ready(sample_ch.ready),
		.sample_bits(sample_ch.sensor_bits),
		.result_valid(result_ch.valid),
		.result_ready(result_ch.ready),
		.result_word({result_ch.action, result_ch.left_dir, result_ch.left_speed,
			result_ch.right_dir, result_ch.right_speed, result_ch.clear_error}),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending(pending),
		.fail_count(fail_count),
		.words_checked(words_checked),
		.turns_done(turns_done),
		.clears_done(clears_done)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

	// Result side: unless steady, each word waits a random number of cycles before ready rises.
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
		end
	end

	task automatic send_sample(input sensor_t v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.sensor_bits <= v;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] spin, input logic [7:0] fwd, input logic [15:0] len);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_SPIN_SPEED;
		cfg_data  <= spin;
		@(posedge clk);
		cfg_index <= REG_FORWARD_SPEED;
		cfg_data  <= fwd;
		@(posedge clk);
		cfg_index <= REG_FORWARD_TICKS;
		cfg_data  <= len;
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_data  <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_ticks = len;
		settings++;
	endtask

	function automatic sensor_t set_bits(int k, sensor_t forbidden);
		sensor_t v;
		int p;
		v = '0;
		while ($countones(v) < k) begin
			p = $urandom_range(0, 15);
			if (!forbidden[p]) v[p] = 1'b1;
		end
		return v;
	endfunction

	function automatic sensor_t turn_opener();
		sensor_t v;
		int k;
		int m;
		k = $urandom_range(6, 14);
		m = (k >= 14) ? 2 : (k >= 12) ? 3 : (k >= 10) ? 4 : (k >= 8) ? 5 : 6;
		case ($urandom_range(0, 5))
			0: v = 16'hFFFF;
			1: v = 16'hFFFF & ~(16'h0001 << $urandom_range(0, 15));
			2: case ($urandom_range(0, 5))
				0: v = 16'hC180;
				1: v = 16'h8380;
				2: v = 16'h81C0;
				3: v = 16'hC380;
				4: v = 16'hC1C0;
				default: v = 16'h83C0;
			endcase
			3: case ($urandom_range(0, 5))
				0: v = 16'h0183;
				1: v = 16'h0381;
				2: v = 16'h01C1;
				3: v = 16'h0383;
				4: v = 16'h01C3;
				default: v = 16'h03C1;
			endcase
			4: v = set_bits(k, (16'h0001 << m) - 16'h0001);
			default: v = set_bits(k, ~(16'hFFFF >> m));
		endcase
		return v;
	endfunction

	function automatic sensor_t random_sample();
		sensor_t v;
		v = '0;
		case ($urandom_range(0, 7))
			1: v = set_bits($urandom_range(0, 5), '0);
			2: for (int r = 0; r < 4; r++) v[r + 4 * $urandom_range(0, 3)] = 1'b1;
			3: for (int r = 0; r < 5; r++) v[r + 5 * $urandom_range(0, (r == 0) ? 3 : 2)] = 1'b1;
			4: v = set_bits($urandom_range(6, 16), '0);
			5: v = turn_opener();
			6: v = $urandom_range(0, 1) ? CENTER_PATTERN : 16'h0000;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic run_turn();
		int fwd_items;
		int spin_items;
		send_sample(turn_opener());
		fwd_items = ((cur_ticks > 40) ? 40 : int'(cur_ticks)) + $urandom_range(0, 2) - 1;
		repeat ((fwd_items < 0) ? 0 : fwd_items) send_sample(16'($urandom));
		spin_items = $urandom_range(0, 5);
		repeat (spin_items) begin
			if ($urandom_range(0, 1))
				send_sample(CENTER_PATTERN ^ (16'h0001 << $urandom_range(0, 15)));
			else
				send_sample(16'($urandom));
		end
		if ($urandom_range(0, 7) != 0) send_sample(CENTER_PATTERN);
	endtask

	initial begin
		int phase;
		int target;
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_index             = REG_SPIN_SPEED;
		cfg_data              = '0;
		sample_ch.valid       = 1'b0;
		sample_ch.sensor_bits = '0;
		steady                = 1'b0;
		sent                  = 0;
		settings              = 1;
		cur_ticks             = FORWARD_TICKS_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Follow-mode classes at the reset settings, then a left turn opening.
		send_sample(16'h0000);
		send_sample(16'h0001);
		send_sample(16'h8000);
		send_sample(16'h0003);
		send_sample(16'h0005);
		send_sample(16'h0007);
		send_sample(16'h000B);
		send_sample(16'h000F);
		send_sample(16'h0017);
		send_sample(16'h001F);
		send_sample(16'hFC3F);
		send_sample(CENTER_PATTERN);
		send_sample(16'h8380);

		// Cut the forward leg short and finish the turn that is under way.
		drain();
		configure(SPIN_SPEED_RESET, FORWARD_SPEED_RESET, 16'd0);
		send_sample(16'h5555);
		send_sample(CENTER_PATTERN);

		drain();
		configure(8'hFF, 8'h00, 16'd0);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(CENTER_PATTERN);
		send_sample(16'h0381);
		send_sample(16'hFFFF);
		send_sample(CENTER_PATTERN);
		send_sample(16'h7FFF);
		send_sample(CENTER_PATTERN);

		phase = 0;
		while (sent < 1523) begin
			drain();
			case ((phase < 3) ? phase : $urandom_range(0, 5))
				0: configure(8'h00, 8'h00, 16'd0);
				1: configure(8'hFF, 8'hFF, 16'd1);
				2: configure(8'($urandom), 8'($urandom), 16'hFFFF);
				default: configure(8'($urandom), 8'($urandom), 16'($urandom_range(0, 12)));
			endcase
			steady = (phase == 3) || ($urandom_range(0, 3) == 0);
			target = sent + ((cur_ticks == 16'hFFFF) ? 30 : 100);
			while (sent < target) begin
				if ($urandom_range(0, 9) < 6)
					run_turn();
				else
					repeat ($urandom_range(1, 5)) send_sample(random_sample());
			end
			phase++;
		end
		drain();

		$display("Sent %0d sensor words over %0d register settings; %0d command words checked.",
			sent, settings, words_checked);
		$display("Completed %0d turns, %0d of them ending with an error clear.",
			turns_done, clears_done);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lss_pkg.sv
rtl/lss_sample_if.sv
rtl/lss_result_if.sv
rtl/lss_front.sv
rtl/lss_queue.sv
rtl/lss_back.sv
rtl/line_sensor_steering_sequencer_unit.sv
rtl/lss_checker.sv
bench/lss_checker.sv
bench/tb.sv
